// File: src/sorted_deadline_task_queue_assert.svh
// assertion macros for the sorted deadline task queue
// expects i_clk and i_rst_n in the scope of use
`ifndef SORTED_DEADLINE_TASK_QUEUE_ASSERT_SVH
`define SORTED_DEADLINE_TASK_QUEUE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SDTQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sdtq assertion failed");

// antecedent implies consequent in the next cycle
`define SDTQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sdtq assertion failed");

`endif

// File: src/sdtq_pkg.sv
`timescale 1ns / 1ps
// shared constants for the sorted deadline task queue
// no dependencies
package sdtq_pkg;

    localparam int TASKS_DEF = 8;
    localparam int MODE_W    = 3;
    localparam int ID_W      = 3;
    localparam int TIME_W    = 32;

    localparam logic [MODE_W-1:0] MODE_DELAY   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EXTEND  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUSPEND = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESUME  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POLL    = 3'd4;

    localparam logic [TIME_W-1:0] SUSPEND_VALUE = 32'hffff_ffff;

endpackage

// File: src/sdtq_if.sv
`timescale 1ns / 1ps
// command and response channel interfaces for the task queue
// depends on sdtq_pkg
interface sdtq_cmd_if import sdtq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] amount;
    logic [TIME_W-1:0] now;

    modport source (output valid, mode, task_id, amount, now, input ready);
    modport sink   (input valid, mode, task_id, amount, now, output ready);
endinterface

interface sdtq_rsp_if import sdtq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   head_task;
    logic [TIME_W-1:0] head_deadline;
    logic              head_due;

    modport source (output valid, head_task, head_deadline, head_due, input ready);
    modport sink   (input valid, head_task, head_deadline, head_due, output ready);
endinterface

// File: src/sorted_deadline_task_queue.sv
`timescale 1ns / 1ps
// channel  | dir | modport            | payload
// i_cmd    | in  | sdtq_cmd_if.sink   | mode, task_id, amount, now
// o_rsp    | out | sdtq_rsp_if.source | head_task, head_deadline, head_due
// one command at a time: the next is taken after the last response is registered
// the deadline memory scan runs one task per cycle through a single compare unit
// polls and ignored commands skip the scan and the move
// reset clears state and deadline valid bits, sets the list to id order at once
// a waiting response is held in its register; the next command is taken meanwhile
// and its own response waits until the register is free
// depends on sdtq_pkg, sdtq_if, sdtq_order and the assertion header
`include "sorted_deadline_task_queue_assert.svh"
module sorted_deadline_task_queue import sdtq_pkg::*; #(
    parameter int TASKS = TASKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sdtq_cmd_if.sink          i_cmd,
    sdtq_rsp_if.source        o_rsp
);

    localparam int AW = $clog2(TASKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_SCAN,
        S_MOVE,
        S_HEAD,
        S_RESP
    } t_state;

    t_state            r_state;
    logic [MODE_W-1:0] r_mode;
    logic [ID_W-1:0]   r_tid;
    logic              r_act;
    logic [TIME_W-1:0] r_amount;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_nd;
    logic [AW-1:0]     r_cnt;
    logic [AW-1:0]     r_place;

    logic              r_out_vld;
    logic [ID_W-1:0]   r_out_task;
    logic [TIME_W-1:0] r_out_dl;
    logic              r_out_due;

    logic [TIME_W-1:0] r_mem [TASKS];
    logic [TASKS-1:0]  r_valid;
    logic [TIME_W-1:0] r_rd_data;
    logic              r_rd_vld;

    logic [AW-1:0]     w_rd_addr;
    logic [TIME_W-1:0] w_rd;
    logic [TIME_W-1:0] w_sum;
    logic [AW-1:0]     w_tid_a;
    logic [AW-1:0]     w_head;
    logic              w_accept;
    logic              w_cmd_act;

    assign w_accept  = i_cmd.valid && i_cmd.ready;
    assign w_cmd_act = (i_cmd.mode <= MODE_RESUME)
                       && (32'(i_cmd.task_id) < 32'(TASKS));
    assign w_tid_a   = AW'(r_tid);
    assign w_rd      = r_rd_vld ? r_rd_data : SUSPEND_VALUE;

    // shared adder: delay from now or extend the stored deadline
    assign w_sum = ((r_mode == MODE_DELAY) ? r_now : w_rd) + r_amount;

    sdtq_order #(
        .TASKS (TASKS)
    ) u_order (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_move  (r_state == S_MOVE),
        .i_tid   (w_tid_a),
        .i_place (r_place),
        .o_head  (w_head)
    );

    always_comb begin
        unique case (r_state)
            S_IDLE:  w_rd_addr = AW'(i_cmd.task_id);
            S_BASE:  w_rd_addr = '0;
            S_SCAN:  w_rd_addr = AW'(r_cnt + 1'b1);
            S_MOVE:  w_rd_addr = w_head;
            S_HEAD:  w_rd_addr = w_head;
            S_RESP:  w_rd_addr = w_head;
            default: w_rd_addr = '0;
        endcase
    end

    // deadline memory, unwritten entries read as suspended
    always_ff @(posedge i_clk) begin
        if (r_state == S_MOVE) begin
            r_mem[w_tid_a] <= r_nd;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (r_state == S_MOVE) begin
                r_valid[w_tid_a] <= 1'b1;
            end
            r_rd_vld <= r_valid[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_act     <= 1'b0;
        end else begin
            if (o_rsp.ready && (r_state != S_RESP)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode   <= i_cmd.mode;
                        r_tid    <= i_cmd.task_id;
                        r_amount <= i_cmd.amount;
                        r_now    <= i_cmd.now;
                        r_act    <= w_cmd_act;
                        r_state  <= S_BASE;
                    end
                end
                S_BASE: begin
                    unique case (r_mode)
                        MODE_DELAY:   r_nd <= w_sum;
                        MODE_EXTEND:  r_nd <= w_sum;
                        MODE_SUSPEND: r_nd <= SUSPEND_VALUE;
                        MODE_RESUME:  r_nd <= r_now;
                        default:      r_nd <= r_nd;
                    endcase
                    r_cnt   <= '0;
                    r_place <= '0;
                    r_state <= r_act ? S_SCAN : S_HEAD;
                end
                S_SCAN: begin
                    // count the other tasks due no later than the new deadline
                    if (r_cnt != w_tid_a && w_rd <= r_nd) begin
                        r_place <= r_place + 1'b1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == AW'(TASKS - 1)) begin
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    r_state <= S_HEAD;
                end
                S_HEAD: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_vld || o_rsp.ready) begin
                        r_out_vld  <= 1'b1;
                        r_out_task <= ID_W'(w_head);
                        r_out_dl   <= w_rd;
                        r_out_due  <= (r_now >= w_rd);
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cmd.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.head_task     = r_out_task;
    assign o_rsp.head_deadline = r_out_dl;
    assign o_rsp.head_due      = r_out_due;

    `SDTQ_ASSERT_NOW(a_rsp_from_resp, $rose(o_rsp.valid), $past(r_state) == S_RESP)
    `SDTQ_ASSERT_NOW(a_place_in_range, r_state == S_MOVE, r_place <= AW'(TASKS - 1))
    `SDTQ_ASSERT_NOW(a_move_only_active, r_state == S_MOVE, r_act)
    `SDTQ_ASSERT_NEXT(a_front_insert, (r_state == S_MOVE) && (r_place == '0), w_head == w_tid_a)

endmodule

// File: src/sdtq_order.sv
`timescale 1ns / 1ps
// ordered list of task ids, earliest deadline in slot 0
// self-contained; driven by the sorted_deadline_task_queue sequencer
module sdtq_order #(
    parameter int TASKS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_move,
    input  logic [$clog2(TASKS)-1:0] i_tid,
    input  logic [$clog2(TASKS)-1:0] i_place,
    output logic [$clog2(TASKS)-1:0] o_head
);

    localparam int AW = $clog2(TASKS);

    logic [AW-1:0] r_order [TASKS];
    logic [AW-1:0] n_order [TASKS];
    logic [AW-1:0] r_slot;
    logic [AW-1:0] n_slot;

    // current slot of the task, one match per list
    always_comb begin
        n_slot = '0;
        for (int i = 0; i < TASKS; i++) begin
            if (r_order[i] == i_tid) begin
                n_slot = n_slot | AW'(i);
            end
        end
    end

    // remove from r_slot and reinsert at i_place, each lane picks a neighbour
    for (genvar g = 0; g < TASKS; g++) begin : g_lane
        logic [AW-1:0] w_left;
        logic [AW-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = r_order[g];
        end else begin : g_mid
            assign w_left = (AW'(g) <= r_slot) ? r_order[g-1] : r_order[g];
        end
        if (g == TASKS - 1) begin : g_last
            assign w_right = r_order[g];
        end else begin : g_rest
            assign w_right = (AW'(g) < r_slot) ? r_order[g] : r_order[g+1];
        end
        always_comb begin
            priority if (AW'(g) < i_place) begin
                n_order[g] = w_right;
            end else if (AW'(g) == i_place) begin
                n_order[g] = i_tid;
            end else begin
                n_order[g] = w_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASKS; i++) begin
                r_order[i] <= AW'(i);
            end
        end else if (i_move) begin
            r_order <= n_order;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_head = r_order[0];

endmodule

// File: tb/sorted_deadline_task_queue_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for sorted_deadline_task_queue: directed and random commands
// are checked against a behavioural model of the deadline list, under random stalls
// depends on sdtq_pkg, sdtq_if and the block itself
module sorted_deadline_task_queue_tb;
    import sdtq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int QUIET_ITEMS    = 150;

    // spare mode codes, treated as poll only
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

    typedef struct packed {
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] deadline;
        logic              due;
    } t_head;

    logic i_clk;
    logic i_rst_n;

    sdtq_cmd_if cmd_if ();
    sdtq_rsp_if rsp_if ();

    sorted_deadline_task_queue #(
        .TASKS (TASKS_DEF)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    logic [TIME_W-1:0] deadline_tbl [TASKS_DEF];
    logic [ID_W-1:0]   task_order   [TASKS_DEF];
    t_head             head_expect_q [$];

    int  fail_count;
    int  sent_count;
    int  checked_count;
    int  due_seen;
    int  suspended_seen;
    int  idle_cycles;
    int  hold_left;
    int  stall_left;
    bit  hold_req;
    bit  tx_idle_en;
    bit  rx_idle_en;
    logic [TIME_W-1:0] tick_now;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // model of the list: take the task out, then insert after all equal or earlier deadlines
    function automatic t_head apply_command(input logic [MODE_W-1:0] mode,
                                            input logic [ID_W-1:0]   tid,
                                            input logic [TIME_W-1:0] amount,
                                            input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] new_dl;
        int                slot;
        int                place;
        t_head             h;
        slot  = 0;
        place = 0;
        if (mode <= MODE_RESUME && tid < TASKS_DEF) begin
            case (mode)
                MODE_DELAY: begin
                    new_dl = now + amount;
                end
                MODE_EXTEND: begin
                    new_dl = deadline_tbl[tid] + amount;
                end
                MODE_SUSPEND: begin
                    new_dl = SUSPEND_VALUE;
                end
                default: begin
                    new_dl = now;
                end
            endcase
            for (int i = 0; i < TASKS_DEF; i++) begin
                if (task_order[i] == tid) begin
                    slot = i;
                end
            end
            for (int i = slot; i < TASKS_DEF - 1; i++) begin
                task_order[i] = task_order[i + 1];
            end
            for (int i = 0; i < TASKS_DEF - 1; i++) begin
                if (deadline_tbl[task_order[i]] <= new_dl) begin
                    place = i + 1;
                end
            end
            for (int i = TASKS_DEF - 1; i > place; i--) begin
                task_order[i] = task_order[i - 1];
            end
            task_order[place] = tid;
            deadline_tbl[tid] = new_dl;
        end
        h.task_id  = task_order[0];
        h.deadline = deadline_tbl[task_order[0]];
        h.due      = (now >= h.deadline);
        return h;
    endfunction

    task automatic send_cmd(input logic [MODE_W-1:0] mode,
                            input logic [ID_W-1:0]   tid,
                            input logic [TIME_W-1:0] amount,
                            input logic [TIME_W-1:0] now);
        cmd_if.valid   <= 1'b1;
        cmd_if.mode    <= mode;
        cmd_if.task_id <= tid;
        cmd_if.amount  <= amount;
        cmd_if.now     <= now;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        head_expect_q.push_back(apply_command(mode, tid, amount, now));
        sent_count++;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (head_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        rsp_if.ready <= 1'b0;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (head_expect_q.size() == 0) begin
                $display("%0t: response with nothing expected, task %0d deadline %h due %b",
                         $time, rsp_if.head_task, rsp_if.head_deadline, rsp_if.head_due);
                fail_count++;
            end else begin
                if (rsp_if.head_task !== head_expect_q[0].task_id) begin
                    $display("%0t: head_task expected %0d actual %0d", $time,
                             head_expect_q[0].task_id, rsp_if.head_task);
                    fail_count++;
                end
                if (rsp_if.head_deadline !== head_expect_q[0].deadline) begin
                    $display("%0t: head_deadline expected %h actual %h", $time,
                             head_expect_q[0].deadline, rsp_if.head_deadline);
                    fail_count++;
                end
                if (rsp_if.head_due !== head_expect_q[0].due) begin
                    $display("%0t: head_due expected %b actual %b", $time,
                             head_expect_q[0].due, rsp_if.head_due);
                    fail_count++;
                end
                if (head_expect_q[0].due) due_seen++;
                if (head_expect_q[0].deadline == SUSPEND_VALUE) suspended_seen++;
                checked_count++;
                void'(head_expect_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_reset_state();
        send_cmd(MODE_POLL, 3'd0, 32'd0, 32'd0);
        send_cmd(MODE_POLL, 3'd7, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    task automatic test_each_mode();
        send_cmd(MODE_DELAY, 3'd3, 32'd100, 32'd0);
        send_cmd(MODE_EXTEND, 3'd3, 32'd50, 32'd120);
        send_cmd(MODE_RESUME, 3'd5, 32'd9, 32'd160);
        send_cmd(MODE_SUSPEND, 3'd5, 32'd0, 32'd170);
        send_cmd(MODE_SPARE_A, 3'd3, 32'd1, 32'd200);
        send_cmd(MODE_SPARE_B, 3'd1, 32'd2, 32'd140);
        send_cmd(MODE_SPARE_C, 3'd0, 32'd3, 32'd151);
    endtask

    task automatic test_equal_deadlines();
        send_cmd(MODE_DELAY, 3'd1, 32'd150, 32'd0);
        send_cmd(MODE_DELAY, 3'd4, 32'd50, 32'd100);
        send_cmd(MODE_RESUME, 3'd2, 32'd0, 32'd150);
        send_cmd(MODE_DELAY, 3'd1, 32'd0, 32'd150);
    endtask

    task automatic test_wraparound();
        send_cmd(MODE_DELAY, 3'd6, 32'hffff_ffff, 32'd2);
        send_cmd(MODE_EXTEND, 3'd6, 32'hffff_fffe, 32'd3);
        send_cmd(MODE_DELAY, 3'd7, 32'hffff_ffff, 32'd0);
        send_cmd(MODE_DELAY, 3'd0, 32'd0, 32'hffff_ffff);
        send_cmd(MODE_EXTEND, 3'd2, 32'hffff_ffff, 32'h8000_0000);
        send_cmd(MODE_SUSPEND, 3'd6, 32'h5555_aaaa, 32'h0000_0000);
    endtask

    task automatic random_cmd();
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] amount;
        int                r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            tick_now = tick_now + $urandom_range(0, 40);
        end else if (r == 7) begin
            tick_now = tick_now + $urandom_range(0, 5000);
        end else if (r == 8) begin
            tick_now = $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 35) begin
            mode = MODE_DELAY;
        end else if (r < 55) begin
            mode = MODE_EXTEND;
        end else if (r < 67) begin
            mode = MODE_SUSPEND;
        end else if (r < 82) begin
            mode = MODE_RESUME;
        end else if (r < 94) begin
            mode = MODE_POLL;
        end else begin
            mode = MODE_W'($urandom_range(5, 7));
        end
        r = $urandom_range(0, 19);
        if (r < 3) begin
            amount = $urandom_range(0, 2);
        end else if (r < 15) begin
            amount = $urandom_range(0, 100);
        end else if (r < 18) begin
            amount = $urandom;
        end else begin
            amount = SUSPEND_VALUE - $urandom_range(0, 50);
        end
        send_cmd(mode, ID_W'($urandom_range(0, TASKS_DEF - 1)), amount, tick_now);
    endtask

    task automatic test_full_backpressure();
        cmd_if.valid <= 1'b0;
        wait_drained();
        hold_req = 1'b1;
        repeat (12) random_cmd();
    endtask

    task automatic test_drain_pause();
        repeat (5) random_cmd();
        cmd_if.valid <= 1'b0;
        wait_drained();
        repeat (5) random_cmd();
    endtask

    task automatic test_random_commands();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            random_cmd();
        end
    endtask

    initial begin
        fail_count     = 0;
        sent_count     = 0;
        checked_count  = 0;
        due_seen       = 0;
        suspended_seen = 0;
        idle_cycles    = 0;
        hold_req       = 1'b0;
        tx_idle_en     = 1'b0;
        rx_idle_en     = 1'b0;
        tick_now       = '0;
        for (int i = 0; i < TASKS_DEF; i++) begin
            deadline_tbl[i] = SUSPEND_VALUE;
            task_order[i]   = ID_W'(i);
        end
        i_rst_n        <= 1'b0;
        cmd_if.valid   <= 1'b0;
        cmd_if.mode    <= MODE_POLL;
        cmd_if.task_id <= '0;
        cmd_if.amount  <= '0;
        cmd_if.now     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_each_mode();
        test_equal_deadlines();
        test_wraparound();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        test_full_backpressure();
        test_drain_pause();
        test_random_commands();

        cmd_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d commands over all modes, checked %0d head reports", sent_count,
                 checked_count);
        $display("heads due: %0d, suspended heads: %0d", due_seen, suspended_seen);
        if (fail_count == 0 && head_expect_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
